/* design/tcs_pkg.sv */
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types for the tetrahedron circumsphere pipeline.
// ----------------------------------------------------------------------------
package tcs_pkg;

  // Pipeline control shared by the top level and its arithmetic units
  typedef struct packed {
    logic adv;   // every stage register loads this cycle
  } tcs_ctl_t;

endpackage

/* design/tetrahedron_circumsphere.sv */
// ----------------------------------------------------------------------------
// tetrahedron_circumsphere
// Circumcenter and circumradius of a tetrahedron by exact determinants.
// ----------------------------------------------------------------------------
// Fully pipelined: one tetrahedron per clock while the output is not stalled,
// results in order. Most of the stages are in the three dividers and the
// square root, which resolve one result bit per stage. A stall while a
// result waits at the output freezes the whole pipeline; no transaction is
// dropped or repeated. Flat tetrahedra give zero outputs with degenerate
// set; out-of-range centers and radii clamp and set saturated.
module tetrahedron_circumsphere #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [COORD_BITS-1:0]          v0_x_i,
  input  logic signed [COORD_BITS-1:0]          v0_y_i,
  input  logic signed [COORD_BITS-1:0]          v0_z_i,
  input  logic signed [COORD_BITS-1:0]          v1_x_i,
  input  logic signed [COORD_BITS-1:0]          v1_y_i,
  input  logic signed [COORD_BITS-1:0]          v1_z_i,
  input  logic signed [COORD_BITS-1:0]          v2_x_i,
  input  logic signed [COORD_BITS-1:0]          v2_y_i,
  input  logic signed [COORD_BITS-1:0]          v2_z_i,
  input  logic signed [COORD_BITS-1:0]          v3_x_i,
  input  logic signed [COORD_BITS-1:0]          v3_y_i,
  input  logic signed [COORD_BITS-1:0]          v3_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [COORD_BITS+FRAC_BITS+1:0] center_x_o,
  output logic signed [COORD_BITS+FRAC_BITS+1:0] center_y_o,
  output logic signed [COORD_BITS+FRAC_BITS+1:0] center_z_o,
  output logic [COORD_BITS+FRAC_BITS:0]         radius_o,
  output logic                                  degenerate_o,
  output logic                                  saturated_o
);
  import tcs_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int CW   = C + FRAC_BITS + 2;     // center width
  localparam int RW   = CW - 1;                // radius width
  localparam int DW   = C + 1;                 // edge vector component
  localparam int PW   = 2 * C + 2;             // component product
  localparam int NW   = 2 * C + 3;             // squared edge length
  localparam int MW   = 2 * C + 3;             // 2x2 minor
  localparam int LW   = C + 2;                 // low split of squared length
  localparam int LOW  = LW + 1 + MW;
  localparam int HIW  = NW - LW + MW;
  localparam int TW   = NW + MW;               // numerator term
  localparam int NUMW = TW + 2;                // numerator
  localparam int ATW  = DW + MW;               // orientation term
  localparam int AW   = 3 * C + 5;             // orientation determinant
  localparam int QB   = CW;                    // quotient bits
  localparam int DL   = QB + 2;                // divider latency
  localparam int RB   = RW + 1;                // root bits
  localparam int SQW  = 2 * RW;
  localparam int IW   = 2 * RW + 2;
  localparam int CE   = CW + 3;
  localparam int NST  = 10 + DL + RB;          // total stages
  localparam int VW   = 3 * C;
  localparam int NV   = 6 + DL;
  localparam int PDW  = 3 + 3 * CW;
  localparam int NPD  = 3 + RB;
  // column pairs of each minor, and row pairs of each cofactor
  localparam int PA [3] = '{1, 0, 0};
  localparam int PB [3] = '{2, 2, 1};

  // flow control
  tcs_ctl_t ctl;
  logic     adv;
  logic     vld_q [NST];

  assign adv         = !vld_q[NST-1] || !out_stall_i;
  assign ctl.adv     = adv;
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // vertex gather
  logic signed [C-1:0] vtx [4][3];
  always_comb begin
    vtx[0] = '{v0_x_i, v0_y_i, v0_z_i};
    vtx[1] = '{v1_x_i, v1_y_i, v1_z_i};
    vtx[2] = '{v2_x_i, v2_y_i, v2_z_i};
    vtx[3] = '{v3_x_i, v3_y_i, v3_z_i};
  end

  // front end registers
  logic signed [DW-1:0]   d1_q   [3][3];   // [row][axis]
  logic signed [PW-1:0]   sq2_q  [3][3];
  logic signed [PW-1:0]   ma2_q  [3][3];   // [pair][row]
  logic signed [PW-1:0]   mb2_q  [3][3];
  logic signed [DW-1:0]   dx2_q  [3];
  logic signed [NW-1:0]   nn3_q  [3];
  logic signed [MW-1:0]   mn3_q  [3][3];
  logic signed [DW-1:0]   dx3_q  [3];
  logic signed [ATW-1:0]  ta4_q  [3];
  logic signed [LOW-1:0]  plo4_q [3][3];
  logic signed [HIW-1:0]  phi4_q [3][3];
  logic signed [AW-1:0]   a5_q;
  logic signed [TW-1:0]   tn5_q  [3][3];
  logic signed [AW-1:0]   a6_q;
  logic signed [NUMW-1:0] num6_q [3];
  logic                   deg6_q;
  logic [VW-1:0]          v0d_q  [NV];
  logic                   degd_q [DL];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // edge vectors from vertex 0
      for (int r = 0; r < 3; r++)
        for (int ax = 0; ax < 3; ax++)
          d1_q[r][ax] <= DW'(vtx[r+1][ax]) - DW'(vtx[0][ax]);
      v0d_q[0] <= {vtx[0][2], vtx[0][1], vtx[0][0]};
      for (int i = 1; i < NV; i++) v0d_q[i] <= v0d_q[i-1];

      // component products
      for (int r = 0; r < 3; r++) begin
        for (int ax = 0; ax < 3; ax++)
          sq2_q[r][ax] <= PW'(d1_q[r][ax]) * PW'(d1_q[r][ax]);
        dx2_q[r] <= d1_q[r][0];
      end
      for (int p = 0; p < 3; p++)
        for (int j = 0; j < 3; j++) begin
          ma2_q[p][j] <= PW'(d1_q[PA[j]][PA[p]]) * PW'(d1_q[PB[j]][PB[p]]);
          mb2_q[p][j] <= PW'(d1_q[PA[j]][PB[p]]) * PW'(d1_q[PB[j]][PA[p]]);
        end

      // squared lengths and minors
      for (int r = 0; r < 3; r++) begin
        nn3_q[r] <= NW'(sq2_q[r][0]) + NW'(sq2_q[r][1]) + NW'(sq2_q[r][2]);
        dx3_q[r] <= dx2_q[r];
      end
      for (int p = 0; p < 3; p++)
        for (int j = 0; j < 3; j++)
          mn3_q[p][j] <= MW'(ma2_q[p][j]) - MW'(mb2_q[p][j]);

      // cofactor products, squared length split in two halves
      for (int j = 0; j < 3; j++) begin
        ta4_q[j] <= ATW'(dx3_q[j]) * ATW'(mn3_q[0][j]);
        for (int p = 0; p < 3; p++) begin
          plo4_q[p][j] <= LOW'($signed({1'b0, nn3_q[j][LW-1:0]})) * LOW'(mn3_q[p][j]);
          phi4_q[p][j] <= HIW'($signed(nn3_q[j][NW-1:LW])) * HIW'(mn3_q[p][j]);
        end
      end

      // orientation determinant and recombined numerator terms
      a5_q <= AW'(ta4_q[0]) - AW'(ta4_q[1]) + AW'(ta4_q[2]);
      for (int p = 0; p < 3; p++)
        for (int j = 0; j < 3; j++)
          tn5_q[p][j] <= (TW'(phi4_q[p][j]) <<< LW) + TW'(plo4_q[p][j]);

      // numerators; the y numerator changes sign
      a6_q   <= a5_q;
      deg6_q <= (a5_q == '0);
      for (int p = 0; p < 3; p++) begin
        if (p == 1)
          num6_q[p] <= -(NUMW'(tn5_q[p][0]) - NUMW'(tn5_q[p][1]) + NUMW'(tn5_q[p][2]));
        else
          num6_q[p] <= NUMW'(tn5_q[p][0]) - NUMW'(tn5_q[p][1]) + NUMW'(tn5_q[p][2]);
      end
      degd_q[0] <= deg6_q;
      for (int i = 1; i < DL; i++) degd_q[i] <= degd_q[i-1];
    end
  end

  // one divider per axis
  logic [QB-1:0] quo [3];
  logic          ovf [3];
  logic          neg [3];

  for (genvar p = 0; p < 3; p++) begin : g_div
    tcs_div #(
      .NUM_W  (NUMW),
      .DEN_W  (AW),
      .FRAC_W (FRAC_BITS),
      .QB     (QB)
    ) u_div (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .num_i (num6_q[p]),
      .den_i (a6_q),
      .quo_o (quo[p]),
      .ovf_o (ovf[p]),
      .neg_o (neg[p])
    );
  end

  // center clamp and radius operands
  logic [PDW-1:0] pd_d;
  logic [RW-1:0]  mag_d [3];

  always_comb begin
    logic [CW-1:0]       cc [3];
    logic                csat;
    logic                rsat;
    logic signed [C-1:0] v0s;
    logic signed [CE-1:0] base;
    logic signed [CE-1:0] relv;
    logic signed [CE-1:0] cs;
    logic                hi;
    logic                lo;
    csat = 1'b0;
    rsat = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      v0s  = $signed(v0d_q[NV-1][ax*C +: C]);
      base = CE'(v0s) <<< FRAC_BITS;
      relv = neg[ax] ? -$signed(CE'(quo[ax])) : $signed(CE'(quo[ax]));
      cs   = base + relv;
      hi   = ovf[ax] ? !neg[ax] : (!cs[CE-1] && (|cs[CE-2:CW-1]));
      lo   = ovf[ax] ? neg[ax]  : (cs[CE-1] && !(&cs[CE-2:CW-1]));
      if (hi)      cc[ax] = {1'b0, {(CW-1){1'b1}}};
      else if (lo) cc[ax] = {1'b1, {(CW-1){1'b0}}};
      else         cc[ax] = cs[CW-1:0];
      csat       = csat | hi | lo;
      rsat       = rsat | ovf[ax] | quo[ax][QB-1];
      mag_d[ax]  = quo[ax][RW-1:0];
    end
    pd_d = {degd_q[DL-1], csat, rsat, cc[2], cc[1], cc[0]};
  end

  // radius squared
  logic [PDW-1:0] pd_q  [NPD];
  logic [RW-1:0]  mag_q [3];
  logic [SQW-1:0] sq_q  [3];
  logic [IW-1:0]  ssum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd_q[0] <= pd_d;
      for (int i = 1; i < NPD; i++) pd_q[i] <= pd_q[i-1];
      for (int ax = 0; ax < 3; ax++) begin
        mag_q[ax] <= mag_d[ax];
        sq_q[ax]  <= SQW'(mag_q[ax]) * SQW'(mag_q[ax]);
      end
      ssum_q <= IW'(sq_q[0]) + IW'(sq_q[1]) + IW'(sq_q[2]);
    end
  end

  logic [RB-1:0] root;

  tcs_sqrt #(
    .IN_W (IW),
    .RT_W (RB)
  ) u_sqrt (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .val_i  (ssum_q),
    .root_o (root)
  );

  // output register
  logic [PDW-1:0]       pd_f;
  logic                 rclamp;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [RW-1:0]        rad_q;
  logic                 deg_q, sat_q;

  assign pd_f   = pd_q[NPD-1];
  assign rclamp = pd_f[3*CW] | root[RB-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pd_f[PDW-1]) begin
        cx_q  <= '0;
        cy_q  <= '0;
        cz_q  <= '0;
        rad_q <= '0;
        deg_q <= 1'b1;
        sat_q <= 1'b0;
      end else begin
        cx_q  <= $signed(pd_f[0 +: CW]);
        cy_q  <= $signed(pd_f[CW +: CW]);
        cz_q  <= $signed(pd_f[2*CW +: CW]);
        rad_q <= rclamp ? {RW{1'b1}} : root[RW-1:0];
        deg_q <= 1'b0;
        sat_q <= pd_f[3*CW+1] | rclamp;
      end
    end
  end

  assign center_x_o   = cx_q;
  assign center_y_o   = cy_q;
  assign center_z_o   = cz_q;
  assign radius_o     = rad_q;
  assign degenerate_o = deg_q;
  assign saturated_o  = sat_q;

endmodule

/* design/tcs_div.sv */
// ----------------------------------------------------------------------------
// tcs_div
// Pipelined rounding divider: |num| * 2^FRAC_W / (2 |den|), ties away from
// zero, one quotient bit per stage. Flags quotients that need more than QB bits.
// ----------------------------------------------------------------------------
module tcs_div #(
  parameter int NUM_W  = 72,
  parameter int DEN_W  = 53,
  parameter int FRAC_W = 8,
  parameter int QB     = 26
) (
  input  logic                    clk_i,
  input  tcs_pkg::tcs_ctl_t       ctl_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DEN_W-1:0] den_i,
  output logic [QB-1:0]           quo_o,
  output logic                    ovf_o,
  output logic                    neg_o
);
  import tcs_pkg::*;

  localparam int XW  = NUM_W + FRAC_W + 1;        // rounded numerator
  localparam int DNW = DEN_W + 1;                 // 2 |den|
  localparam int RRW = DNW + QB;                  // working remainder
  localparam int OW  = ((XW > RRW) ? XW : RRW) + 1;

  // stage A: magnitudes and rounding offset
  logic [XW-1:0]    nx_q;
  logic [DNW-1:0]   dn_a_q;
  logic             neg_a_q;
  // stage B: range check, then one register per quotient bit
  logic [RRW-1:0]   r_q   [QB+1];
  logic [DNW-1:0]   dn_q  [QB+1];
  logic [QB-1:0]    q_q   [QB+1];
  logic             neg_q [QB+1];
  logic             ovf_q [QB+1];

  logic [NUM_W-1:0] nabs;
  logic [DEN_W-1:0] dabs;
  logic [XW-1:0]    nx_d;
  logic             ovf_d;
  logic [RRW-1:0]   rb_d;
  logic [RRW-1:0]   r_d   [QB];
  logic [QB-1:0]    q_d   [QB];

  // magnitudes, numerator scaled and offset by |den| for rounding
  always_comb begin
    nabs = num_i[NUM_W-1] ? NUM_W'(~num_i + 1'b1) : NUM_W'(num_i);
    dabs = den_i[DEN_W-1] ? DEN_W'(~den_i + 1'b1) : DEN_W'(den_i);
    nx_d = (XW'(nabs) << FRAC_W) + XW'(dabs);
  end

  // quotient too large for QB bits
  always_comb begin
    ovf_d = OW'(nx_q) >= (OW'(dn_a_q) << QB);
    rb_d  = ovf_d ? '0 : RRW'(nx_q);
  end

  // restoring steps, most significant quotient bit first
  always_comb begin
    for (int i = 1; i <= QB; i++) begin
      logic [RRW-1:0] trial;
      trial = RRW'(dn_q[i-1]) << (QB - i);
      if (r_q[i-1] >= trial) begin
        r_d[i-1] = r_q[i-1] - trial;
        q_d[i-1] = q_q[i-1] | (QB'(1) << (QB - i));
      end else begin
        r_d[i-1] = r_q[i-1];
        q_d[i-1] = q_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      nx_q     <= nx_d;
      dn_a_q   <= {dabs, 1'b0};
      neg_a_q  <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      r_q[0]   <= rb_d;
      dn_q[0]  <= dn_a_q;
      q_q[0]   <= '0;
      neg_q[0] <= neg_a_q;
      ovf_q[0] <= ovf_d;
      for (int i = 1; i <= QB; i++) begin
        r_q[i]   <= r_d[i-1];
        dn_q[i]  <= dn_q[i-1];
        q_q[i]   <= q_d[i-1];
        neg_q[i] <= neg_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
      end
    end
  end

  assign quo_o = q_q[QB];
  assign ovf_o = ovf_q[QB];
  assign neg_o = neg_q[QB];

endmodule

/* design/tcs_sqrt.sv */
// ----------------------------------------------------------------------------
// tcs_sqrt
// Pipelined integer square root, floor(sqrt(val)), one root bit per stage.
// ----------------------------------------------------------------------------
module tcs_sqrt #(
  parameter int IN_W = 52,
  parameter int RT_W = 26
) (
  input  logic              clk_i,
  input  tcs_pkg::tcs_ctl_t ctl_i,
  input  logic [IN_W-1:0]   val_i,
  output logic [RT_W-1:0]   root_o
);
  import tcs_pkg::*;

  localparam int SW = ((IN_W > 2 * RT_W) ? IN_W : 2 * RT_W) + 1;

  logic [SW-1:0]   rem_q [RT_W];
  logic [RT_W-1:0] rt_q  [RT_W];
  logic [SW-1:0]   rem_d [RT_W];
  logic [RT_W-1:0] rt_d  [RT_W];

  // remainder holds val - root^2; try adding 2^k to the root
  always_comb begin
    for (int i = 0; i < RT_W; i++) begin
      logic [SW-1:0]   rem_s;
      logic [RT_W-1:0] rt_s;
      logic [SW-1:0]   inc;
      rem_s = (i == 0) ? SW'(val_i) : rem_q[(i == 0) ? 0 : i - 1];
      rt_s  = (i == 0) ? '0 : rt_q[(i == 0) ? 0 : i - 1];
      inc   = (SW'(rt_s) << (RT_W - i)) + (SW'(1) << (2 * (RT_W - 1 - i)));
      if (rem_s >= inc) begin
        rem_d[i] = rem_s - inc;
        rt_d[i]  = rt_s | (RT_W'(1) << (RT_W - 1 - i));
      end else begin
        rem_d[i] = rem_s;
        rt_d[i]  = rt_s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      for (int i = 0; i < RT_W; i++) begin
        rem_q[i] <= rem_d[i];
        rt_q[i]  <= rt_d[i];
      end
    end
  end

  assign root_o = rt_q[RT_W-1];

endmodule

/* dv/tb_tetrahedron_circumsphere.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tetrahedron_circumsphere
// Self-checking bench for the tetrahedron circumsphere pipeline.
// A table of directed tetrahedra runs first: extremes, flat cases and far
// centers. Random tetrahedra follow: most small, some at full range, some
// forced flat. Both channels idle at random. Every result is compared field by
// field with an in-order queue of table rows or behavioral predictions.
// ----------------------------------------------------------------------------
module tb_tetrahedron_circumsphere;

  localparam int CB = 16;
  localparam int FB = 8;
  localparam int CW = CB + FB + 2;
  localparam int RW = CB + FB + 1;
  localparam int LATENCY = 12 + 2 * (CB + FB + 2);
  localparam int N_RANDOM = 1600;
  localparam longint CMAX = 33554431;
  localparam longint CMIN = -33554432;
  localparam longint RMAX = 33554431;
  localparam longint RCAP = 64'sd1 << 60;

  typedef struct {
    logic signed [CW-1:0] cx, cy, cz;
    logic [RW-1:0]        rad;
    logic                 degen, sat;
  } sphere_t;

  typedef struct {
    logic signed [CB-1:0] c [12];
    logic                 typed;  // expected result given in the row
    sphere_t              res;
  } tet_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic signed [CB-1:0] vin [12];
  logic in_stall_o, out_valid_o;
  logic signed [CW-1:0] center_x_o, center_y_o, center_z_o;
  logic [RW-1:0] radius_o;
  logic degenerate_o, saturated_o;

  sphere_t spheres_due [$];
  int errors = 0;

  initial for (int i = 0; i < 12; i++) vin[i] = '0;

  tetrahedron_circumsphere uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .v0_x_i(vin[0]), .v0_y_i(vin[1]), .v0_z_i(vin[2]),
    .v1_x_i(vin[3]), .v1_y_i(vin[4]), .v1_z_i(vin[5]),
    .v2_x_i(vin[6]), .v2_y_i(vin[7]), .v2_z_i(vin[8]),
    .v3_x_i(vin[9]), .v3_y_i(vin[10]), .v3_z_i(vin[11]),
    .out_valid_o, .out_stall_i,
    .center_x_o, .center_y_o, .center_z_o, .radius_o, .degenerate_o, .saturated_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rounded offset N*2^FB/(2a), ties away from zero, capped
  function automatic longint center_offset(logic signed [127:0] num, logic signed [127:0] a);
    logic [127:0] n, d, q;
    logic neg;
    neg = num[127] ^ a[127];
    n = num[127] ? -num : num;
    d = a[127] ? -a : a;
    q = ((n << FB) + d) / (d << 1);
    if (q > RCAP) q = RCAP;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic signed [127:0] det3(longint c[3], longint p[3], longint q[3]);
    logic signed [127:0] t0, t1, t2;
    t0 = 128'(c[0]) * 128'(p[1] * q[2] - q[1] * p[2]);
    t1 = 128'(c[1]) * 128'(p[0] * q[2] - q[0] * p[2]);
    t2 = 128'(c[2]) * 128'(p[0] * q[1] - q[0] * p[1]);
    return t0 - t1 + t2;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic sphere_t predict_sphere(logic signed [CB-1:0] c [12]);
    longint o[3], dx[3], dy[3], dz[3], nn[3], rel[3], cc;
    logic signed [127:0] a, num[3];
    logic [63:0] s, rad;
    sphere_t r;
    r = '{default: '0};
    for (int i = 0; i < 3; i++) o[i] = longint'(c[i]);
    for (int i = 0; i < 3; i++) begin
      dx[i] = longint'(c[3*i+3]) - o[0];
      dy[i] = longint'(c[3*i+4]) - o[1];
      dz[i] = longint'(c[3*i+5]) - o[2];
      nn[i] = dx[i]*dx[i] + dy[i]*dy[i] + dz[i]*dz[i];
    end
    a = det3(dx, dy, dz);
    if (a == 0) begin
      r.degen = 1'b1;
      return r;
    end
    num[0] = det3(nn, dy, dz);
    num[1] = -det3(nn, dx, dz);
    num[2] = det3(nn, dx, dy);
    for (int i = 0; i < 3; i++) begin
      rel[i] = center_offset(num[i], a);
      cc = o[i] * 256 + rel[i];
      if (cc > CMAX) begin cc = CMAX; r.sat = 1'b1; end
      if (cc < CMIN) begin cc = CMIN; r.sat = 1'b1; end
      if (i == 0) r.cx = cc[CW-1:0];
      else if (i == 1) r.cy = cc[CW-1:0];
      else r.cz = cc[CW-1:0];
    end
    rad = 0;
    for (int i = 0; i < 3; i++)
      if (rel[i] > RMAX || rel[i] < -RMAX) rad = RMAX + 1;
    if (rad == 0) begin
      s = 0;
      for (int i = 0; i < 3; i++) s += 64'(rel[i] * rel[i]);
      rad = root_floor(s);
    end
    if (rad > RMAX) begin rad = RMAX; r.sat = 1'b1; end
    r.rad = rad[RW-1:0];
    return r;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Drive one transaction and wait for its acceptance; called right after a
  // rising edge, valid stays high when the next transaction follows at once
  task automatic send_tet(logic signed [CB-1:0] c [12], sphere_t res);
    int g;
    g = ($urandom_range(0, 3) == 0) ? short_gap() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < 12; i++) vin[i] <= c[i];
    spheres_due.push_back(res);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Random tetrahedron: small around a random origin, full range, or forced flat
  function automatic void rand_tet(ref logic signed [CB-1:0] c [12]);
    int kind, sp;
    logic signed [CB-1:0] base [3];
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      for (int i = 0; i < 12; i++) c[i] = CB'($urandom());
    end else begin
      sp = (kind < 6) ? 64 : ((kind < 9) ? 2000 : 16);
      for (int i = 0; i < 3; i++) base[i] = CB'($urandom());
      for (int i = 0; i < 12; i++)
        c[i] = base[i % 3] + CB'($urandom_range(0, 2 * sp) - sp);
      if (kind == 9)  // force coplanar: vertex 3 onto vertex 1
        for (int i = 0; i < 3; i++) c[9+i] = c[3+i];
    end
  endfunction

  // Output side: random stall and checking
  always @(posedge clk_i) begin
    sphere_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (spheres_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = spheres_due.pop_front();
        if (center_x_o !== e.cx || center_y_o !== e.cy || center_z_o !== e.cz ||
            radius_o !== e.rad || degenerate_o !== e.degen || saturated_o !== e.sat) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d %0d %0d r%0d d%0b s%0b got %0d %0d %0d r%0d d%0b s%0b",
                     e.cx, e.cy, e.cz, e.rad, e.degen, e.sat, center_x_o, center_y_o,
                     center_z_o, radius_o, degenerate_o, saturated_o);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= short_gap();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  tet_row_t rows [$];

  initial begin
    tet_row_t row;
    logic signed [CB-1:0] c [12];
    sphere_t none;
    int k;
    none = '{default: '0};
    // All vertices coincident at zero: flat
    row.c = '{default: '0}; row.typed = 1; row.res = '{default: '0}; row.res.degen = 1;
    rows.push_back(row);
    // All at the most negative value: flat
    row.c = '{default: 16'sh8000}; rows.push_back(row);
    // All at the most positive value: flat
    row.c = '{default: 16'sh7fff}; rows.push_back(row);
    // Collinear along x
    row.c = '{0,0,0, 1,0,0, 2,0,0, 3,0,0}; rows.push_back(row);
    // Coplanar in z = 0
    row.c = '{0,0,0, 5,0,0, 0,5,0, 5,5,0}; rows.push_back(row);
    row.typed = 0; row.res = none;
    // Unit corner tetrahedron and scaled copies
    row.c = '{0,0,0, 1,0,0, 0,1,0, 0,0,1}; rows.push_back(row);
    row.c = '{0,0,0, 2,0,0, 0,2,0, 0,0,2}; rows.push_back(row);
    row.c = '{0,0,0, -3,0,0, 0,7,0, 0,0,-5}; rows.push_back(row);
    // Full-span corners at the extremes
    row.c = '{-32768,-32768,-32768, 32767,-32768,-32768, -32768,32767,-32768,
              -32768,-32768,32767}; rows.push_back(row);
    row.c = '{32767,32767,32767, -32768,32767,32767, 32767,-32768,32767,
              32767,32767,-32768}; rows.push_back(row);
    // Nearly flat sliver: center far away, saturates
    row.c = '{0,0,0, 32767,0,0, 0,32767,0, 16384,16384,1}; rows.push_back(row);
    row.c = '{-32768,0,0, 32767,0,0, 0,32767,0, 1,1,1}; rows.push_back(row);
    row.c = '{0,0,0, 30000,1,0, -30000,1,0, 0,2,1}; rows.push_back(row);
    // Rounding ties and negative offsets
    row.c = '{0,0,0, 1,0,0, 0,3,0, 0,0,7}; rows.push_back(row);
    row.c = '{100,-200,300, 99,-200,300, 100,-203,300, 100,-200,293}; rows.push_back(row);
    row.c = '{0,0,0, 0,0,1, 0,1,0, 1,0,0}; rows.push_back(row);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[i]) begin
      c = rows[i].c;
      send_tet(c, rows[i].typed ? rows[i].res : predict_sphere(c));
    end
    for (k = 0; k < N_RANDOM; k++) begin
      // hold off once until the pipeline drains
      if (k == N_RANDOM / 2) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (spheres_due.size() != 0);
      end
      rand_tet(c);
      send_tet(c, predict_sphere(c));
    end
    in_valid_i <= 1'b0;
    while (spheres_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
design/tcs_pkg.sv
design/tcs_div.sv
design/tcs_sqrt.sv
design/tetrahedron_circumsphere.sv
dv/tb_tetrahedron_circumsphere.sv
